// ===== design/sha1md_pkg.sv =====
`default_nettype none

package sha1md_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        last_word;
    } t_out_item;

    typedef enum logic [1:0] {
        BYTE_DATA,
        BYTE_PAD80,
        BYTE_ZERO,
        BYTE_LEN
    } t_byte_sel;

    // commands from the controller to the datapath
    typedef struct packed {
        logic      push;
        t_byte_sel byte_sel;
        logic [2:0] len_idx;
        logic      len_add;
        logic      load;
        logic      round;
        logic      add;
        logic      init;
        logic [2:0] word_sel;
    } t_cmd;

    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
    } t_status;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [31:0] K_00_19 = 32'h5A827999;
    localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
    localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
    localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam int unsigned NUM_ROUNDS = 80;
    localparam int unsigned NUM_WORDS  = 5;

endpackage

`default_nettype wire

// ===== design/sha1md_datapath.sv =====
`default_nettype none

module sha1md_datapath
    import sha1md_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [7:0]  i_data_byte,
    input  wire t_cmd        i_cmd,
    output t_status          o_status,
    output logic [31:0]      o_digest_word
);

    localparam logic [6:0] LAST_ROUND = 7'(NUM_ROUNDS - 1);

    logic [31:0] r_w [16];
    logic [23:0] r_acc;
    logic [5:0]  r_fill;
    logic [63:0] r_len;
    logic [31:0] r_h [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [6:0]  r_round;

    logic [7:0]  push_byte;
    logic [31:0] f_val, k_val, t_val, w_new;

    always_comb begin
        unique case (i_cmd.byte_sel)
            BYTE_DATA:  push_byte = i_data_byte;
            BYTE_PAD80: push_byte = PAD_BYTE;
            BYTE_ZERO:  push_byte = 8'h00;
            BYTE_LEN:   push_byte = r_len[8 * (3'd7 - i_cmd.len_idx) +: 8];
            default:    push_byte = 8'h00;
        endcase
    end

    always_comb begin
        if (r_round < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = K_00_19;
        end else if (r_round < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_20_39;
        end else if (r_round < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = K_40_59;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_60_79;
        end
        t_val = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + r_w[0];
    end

    // schedule word sixteen ahead of the window head
    always_comb begin
        logic [31:0] x;
        x = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_new = {x[30:0], x[31]};
    end

    // message window: bytes and schedule words both enter at the tail
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && (r_fill[1:0] == 2'd3)) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= {r_acc, push_byte};
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= w_new;
        end
        if (i_cmd.push) begin
            r_acc <= {r_acc[15:0], push_byte};
        end
        if (i_cmd.load) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_cmd.round) begin
            r_a <= t_val;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_len   <= '0;
            r_round <= '0;
            r_h[0]  <= H0_INIT;
            r_h[1]  <= H1_INIT;
            r_h[2]  <= H2_INIT;
            r_h[3]  <= H3_INIT;
            r_h[4]  <= H4_INIT;
        end else begin
            if (i_cmd.push) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.init) begin
                r_len <= '0;
            end else if (i_cmd.len_add) begin
                r_len <= r_len + 64'd8;
            end
            if (i_cmd.load) begin
                r_round <= '0;
            end else if (i_cmd.round) begin
                r_round <= r_round + 7'd1;
            end
            if (i_cmd.init) begin
                r_h[0] <= H0_INIT;
                r_h[1] <= H1_INIT;
                r_h[2] <= H2_INIT;
                r_h[3] <= H3_INIT;
                r_h[4] <= H4_INIT;
            end else if (i_cmd.add) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
        end
    end

    always_comb begin
        unique case (i_cmd.word_sel)
            3'd0:    o_digest_word = r_h[0];
            3'd1:    o_digest_word = r_h[1];
            3'd2:    o_digest_word = r_h[2];
            3'd3:    o_digest_word = r_h[3];
            3'd4:    o_digest_word = r_h[4];
            default: o_digest_word = r_h[0];
        endcase
    end

    assign o_status.fill       = r_fill;
    assign o_status.round_last = (r_round == LAST_ROUND);

endmodule

`default_nettype wire

// ===== design/sha1md_ctrl.sv =====
`default_nettype none

module sha1md_ctrl
    import sha1md_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire logic    i_byte_valid,
    input  wire logic    i_end_of_message,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output logic         o_last_word,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [5:0] FILL_FULL = 6'd63;
    localparam logic [5:0] FILL_LEN  = 6'd56;
    localparam logic [2:0] LAST_LEN  = 3'd7;
    localparam logic [2:0] LAST_WORD = 3'(NUM_WORDS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD80,
        S_PADZ,
        S_PADLEN,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    t_state     r_state, n_state;
    t_state     r_ret, n_ret;
    logic [2:0] r_len_idx, n_len_idx;
    logic [2:0] r_word, n_word;
    logic       in_acc;

    assign in_acc = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_len_idx = r_len_idx;
        n_word    = r_word;
        o_cmd          = '0;
        o_cmd.byte_sel = BYTE_DATA;
        o_cmd.len_idx  = r_len_idx;
        o_cmd.word_sel = r_word;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_byte_valid) begin
                        o_cmd.push    = 1'b1;
                        o_cmd.len_add = 1'b1;
                    end
                    if (i_byte_valid && (i_status.fill == FILL_FULL)) begin
                        n_state = S_LOAD;
                        n_ret   = i_end_of_message ? S_PAD80 : S_IDLE;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD80;
                    end
                end
            end
            S_PAD80: begin
                o_cmd.push     = 1'b1;
                o_cmd.byte_sel = BYTE_PAD80;
                if (i_status.fill == FILL_FULL) begin
                    n_state = S_LOAD;
                    n_ret   = S_PADZ;
                end else begin
                    n_state = S_PADZ;
                end
            end
            S_PADZ: begin
                if (i_status.fill == FILL_LEN) begin
                    n_state   = S_PADLEN;
                    n_len_idx = '0;
                end else begin
                    o_cmd.push     = 1'b1;
                    o_cmd.byte_sel = BYTE_ZERO;
                    if (i_status.fill == FILL_FULL) begin
                        n_state = S_LOAD;
                        n_ret   = S_PADZ;
                    end
                end
            end
            S_PADLEN: begin
                o_cmd.push     = 1'b1;
                o_cmd.byte_sel = BYTE_LEN;
                n_len_idx      = r_len_idx + 3'd1;
                if (r_len_idx == LAST_LEN) begin
                    n_state = S_LOAD;
                    n_ret   = S_OUT;
                    n_word  = '0;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_status.round_last) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = r_ret;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_word == LAST_WORD) begin
                        o_cmd.init = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_word = r_word + 3'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_len_idx <= '0;
            r_word    <= '0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_len_idx <= n_len_idx;
            r_word    <= n_word;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_last_word = (r_word == LAST_WORD);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while digest pending");

    a_full_compress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_byte_valid && (i_status.fill == FILL_FULL)) |=> o_cmd.load)
        else $error("full block did not start compression");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_word) |=> o_in_ready)
        else $error("not ready after final digest word");

    a_rounds_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.add |-> $past(o_cmd.round) && $past(i_status.round_last))
        else $error("chain update without final round");

endmodule

`default_nettype wire

// ===== design/sha1_message_digest_unit.sv =====
// input: each valid byte is taken in its input transfer; a block that fills is then compressed
// (load, 80 rounds at one per cycle in the round adder, chain update)
// end of message: padding goes in at one byte a cycle while no compression runs, with
// one or two compressions in all, then five digest words, one per output transaction; no input is taken meanwhile
// reset: synchronous active low, loads the initial hash words and clears length and fill
`default_nettype none

module sha1_message_digest_unit
    import sha1md_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    t_cmd    cmd;
    t_status status;
    logic    last_word;
    logic [31:0] digest_word;

    sha1md_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_byte_valid     (i_in_data.byte_valid),
        .i_end_of_message (i_in_data.end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_last_word      (last_word),
        .i_status         (status),
        .o_cmd            (cmd)
    );

    sha1md_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_in_data.data_byte),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_digest_word (digest_word)
    );

    assign o_out_data.digest_word = digest_word;
    assign o_out_data.last_word   = last_word;

endmodule

`default_nettype wire
